>>> design/rrts_pkg.sv
// shared types and constants of the round robin thread scheduler
// no dependencies; used by rrts_ctrl, rrts_dpath and the top level
`default_nettype none
package rrts_pkg;

  // slot status codes
  localparam logic [1:0] ST_INVALID  = 2'd0;
  localparam logic [1:0] ST_ACTIVE   = 2'd1;
  localparam logic [1:0] ST_BLOCKED  = 2'd2;
  localparam logic [1:0] ST_FINISHED = 2'd3;

  // opcodes of an input word
  localparam logic [2:0] OP_CREATE = 3'd0;
  localparam logic [2:0] OP_YIELD  = 3'd1;
  localparam logic [2:0] OP_JOIN   = 3'd2;
  localparam logic [2:0] OP_EXIT   = 3'd3;
  localparam logic [2:0] OP_TICK   = 3'd4;

  localparam int unsigned OpWidth   = 3;
  localparam int unsigned SlotWidth = 3;
  localparam int unsigned DataWidth = 8;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic scan_run;
    logic rd_join;
    logic wr_join;
    logic wr_exit;
    logic wr_wake;
    logic push;
  } rrts_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [OpWidth-1:0] opcode;
    logic               preempt;
    logic               cur_act;
    logic               scan_hit;
    logic               scan_miss;
    logic               join_pre;
    logic               join_ok;
    logic               exit_jv;
    logic               out_free;
  } rrts_sts_t;

endpackage
`default_nettype wire

>>> design/rrts_ram.sv
// generic single write port ram with registered read
// no dependencies
`default_nettype none
module rrts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                     wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                     rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

>>> design/rrts_ctrl.sv
// controller state machine of the round robin thread scheduler
// depends on rrts_pkg (command and status structs, opcodes)
`default_nettype none
module rrts_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_valid_i,
  output logic                   s_ready_o,
  input  wire rrts_pkg::rrts_sts_t sts_i,
  output rrts_pkg::rrts_cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECODE  = 4'd1;
  localparam logic [3:0] S_SCAN    = 4'd2;
  localparam logic [3:0] S_JOIN_RD = 4'd3;
  localparam logic [3:0] S_JOIN_EV = 4'd4;
  localparam logic [3:0] S_EXIT_RD = 4'd5;
  localparam logic [3:0] S_EXIT_EV = 4'd6;
  localparam logic [3:0] S_WAKE    = 4'd7;
  localparam logic [3:0] S_DONE    = 4'd8;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign s_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (s_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts_i.opcode)
          rrts_pkg::OP_CREATE, rrts_pkg::OP_YIELD: state_d = S_SCAN;
          rrts_pkg::OP_TICK: state_d = sts_i.preempt ? S_SCAN : S_DONE;
          rrts_pkg::OP_JOIN: state_d = sts_i.join_pre ? S_JOIN_RD : S_DONE;
          rrts_pkg::OP_EXIT: state_d = sts_i.cur_act ? S_EXIT_RD : S_DONE;
          default: state_d = S_DONE;
        endcase
      end
      S_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (sts_i.scan_hit || sts_i.scan_miss) begin
          state_d = S_DONE;
        end
      end
      S_JOIN_RD: begin
        cmd_o.rd_join = 1'b1;
        state_d       = S_JOIN_EV;
      end
      S_JOIN_EV: begin
        cmd_o.wr_join = sts_i.join_ok;
        state_d       = S_DONE;
      end
      S_EXIT_RD: begin
        // the datapath reads the running slot when no other read is asked for
        state_d = S_EXIT_EV;
      end
      S_EXIT_EV: begin
        cmd_o.wr_exit = 1'b1;
        state_d       = sts_i.exit_jv ? S_WAKE : S_SCAN;
      end
      S_WAKE: begin
        cmd_o.wr_wake = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> design/rrts_dpath.sv
// datapath of the round robin thread scheduler: slot tables, scan counter,
// running slot and output register; depends on rrts_pkg and rrts_ram
`default_nettype none
module rrts_dpath #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic                               cfg_wdata_i,
  input  wire logic [rrts_pkg::DataWidth-1:0]     s_data_i,
  output logic                                    m_valid_o,
  input  wire logic                               m_ready_i,
  output logic      [rrts_pkg::DataWidth-1:0]     m_data_o,
  input  wire rrts_pkg::rrts_cmd_t                cmd_i,
  output rrts_pkg::rrts_sts_t                     sts_o
);

  localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned CW = SW + 1;
  localparam int unsigned XW = (SW > rrts_pkg::SlotWidth) ? SW : rrts_pkg::SlotWidth;
  localparam int unsigned TW = XW + 1;
  localparam int unsigned JW = SW + 1;
  localparam logic [CW-1:0] CountN = CW'(SLOT_COUNT);

  logic [rrts_pkg::OpWidth-1:0]   op_q;
  logic [rrts_pkg::SlotWidth-1:0] tgt_q;
  logic [SW-1:0] cur_q, cur_d;
  logic          cur_act_q, cur_act_d;
  logic          preempt_q;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          issued_q, issued_d;
  logic          last_q, last_d;
  logic [SW-1:0] raddr_q, raddr;
  logic [SW-1:0] new_q, new_d;
  logic          succ_q, succ_d;
  logic [SW-1:0] j_q;
  logic          out_valid_q;
  logic [rrts_pkg::DataWidth-1:0] out_q;
  logic [SLOT_COUNT-1:0] st_vld_q, jn_vld_q;

  // ram ports
  logic          st_we, jn_we;
  logic [SW-1:0] st_waddr, jn_waddr;
  logic [1:0]    st_wdata, st_rdata, st_ent;
  logic [JW-1:0] jn_wdata, jn_rdata, jn_ent;

  rrts_ram #(.WIDTH(2), .DEPTH(SLOT_COUNT)) u_st_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (raddr),
    .rdata_o (st_rdata)
  );

  rrts_ram #(.WIDTH(JW), .DEPTH(SLOT_COUNT)) u_jn_ram (
    .clk_i   (clk_i),
    .we_i    (jn_we),
    .waddr_i (jn_waddr),
    .wdata_i (jn_wdata),
    .raddr_i (raddr),
    .rdata_o (jn_rdata)
  );

  // entries never written read as their reset value
  assign st_ent = st_vld_q[raddr_q] ? st_rdata :
                  ((raddr_q == '0) ? rrts_pkg::ST_ACTIVE : rrts_pkg::ST_INVALID);
  assign jn_ent = jn_vld_q[raddr_q] ? jn_rdata : '0;

  // scan address generation
  logic          is_create;
  logic [CW-1:0] limit, base, sum;
  logic [SW-1:0] scan_addr;
  logic          scan_issue, match, scan_eval, hit, miss;

  assign is_create  = (op_q == rrts_pkg::OP_CREATE);
  assign limit      = is_create ? (CountN - CW'(1)) : CountN;
  assign base       = is_create ? '0 : CW'(cur_q);
  assign sum        = base + cnt_q;
  assign scan_addr  = (sum >= CountN) ? SW'(sum - CountN) : SW'(sum);
  assign scan_issue = cmd_i.scan_run && (cnt_q <= limit);
  assign match      = is_create ? (st_ent == rrts_pkg::ST_INVALID) :
                                  (st_ent == rrts_pkg::ST_ACTIVE);
  assign scan_eval  = cmd_i.scan_run && issued_q;
  assign hit        = scan_eval && match;
  assign miss       = scan_eval && last_q && !match;

  // join target check
  logic [TW-1:0] tgt_w;
  logic [SW-1:0] tgt_idx;
  logic          join_pre;

  assign tgt_w    = TW'(tgt_q);
  assign tgt_idx  = tgt_w[SW-1:0];
  assign join_pre = (tgt_w < TW'(SLOT_COUNT)) && (tgt_idx != cur_q) && cur_act_q;

  always_comb begin
    if (scan_issue) begin
      raddr = scan_addr;
    end else if (cmd_i.rd_join) begin
      raddr = tgt_idx;
    end else begin
      raddr = cur_q;
    end
  end

  always_comb begin
    cnt_d     = cmd_i.scan_run ? cnt_q : CW'(1);
    issued_d  = scan_issue;
    last_d    = scan_issue && (cnt_q == limit);
    if (scan_issue) begin
      cnt_d = cnt_q + CW'(1);
    end
    cur_d     = cur_q;
    cur_act_d = cur_act_q;
    new_d     = new_q;
    succ_d    = succ_q;
    st_we     = 1'b0;
    st_waddr  = cur_q;
    st_wdata  = rrts_pkg::ST_ACTIVE;
    jn_we     = 1'b0;
    jn_waddr  = cur_q;
    jn_wdata  = '0;

    if (cmd_i.load_in) begin
      new_d  = '0;
      succ_d = 1'b0;
    end

    if (hit) begin
      succ_d = 1'b1;
      if (is_create) begin
        // new thread: active with a cleared joiner
        new_d    = raddr_q;
        st_we    = 1'b1;
        st_waddr = raddr_q;
        jn_we    = 1'b1;
        jn_waddr = raddr_q;
      end else begin
        cur_d     = raddr_q;
        cur_act_d = 1'b1;
      end
    end

    if (cmd_i.wr_join) begin
      st_we     = 1'b1;
      st_waddr  = cur_q;
      st_wdata  = rrts_pkg::ST_BLOCKED;
      jn_we     = 1'b1;
      jn_waddr  = tgt_idx;
      jn_wdata  = {1'b1, cur_q};
      cur_d     = tgt_idx;
      cur_act_d = 1'b1;
      succ_d    = 1'b1;
    end

    if (cmd_i.wr_exit) begin
      st_we     = 1'b1;
      st_waddr  = cur_q;
      st_wdata  = rrts_pkg::ST_FINISHED;
      jn_we     = 1'b1;
      jn_waddr  = cur_q;
      jn_wdata  = {1'b0, jn_ent[SW-1:0]};
      cur_act_d = 1'b0;
    end

    if (cmd_i.wr_wake) begin
      st_we     = 1'b1;
      st_waddr  = j_q;
      st_wdata  = rrts_pkg::ST_ACTIVE;
      cur_d     = j_q;
      cur_act_d = 1'b1;
      succ_d    = 1'b1;
    end
  end

  logic join_ok;
  assign join_ok = (st_ent == rrts_pkg::ST_ACTIVE) && !jn_ent[SW];

  // result word: running slot, new slot, success
  logic [XW-1:0] cur_x, new_x;
  assign cur_x = XW'(cur_q);
  assign new_x = XW'(new_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_q       <= '0;
      cur_act_q   <= 1'b1;
      preempt_q   <= 1'b0;
      cnt_q       <= CW'(1);
      issued_q    <= 1'b0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
      st_vld_q    <= '0;
      jn_vld_q    <= '0;
    end else begin
      cur_q     <= cur_d;
      cur_act_q <= cur_act_d;
      cnt_q     <= cnt_d;
      issued_q  <= issued_d;
      last_q    <= last_d;
      if (cfg_we_i) begin
        preempt_q <= cfg_wdata_i;
      end
      if (st_we) begin
        st_vld_q[st_waddr] <= 1'b1;
      end
      if (jn_we) begin
        jn_vld_q[jn_waddr] <= 1'b1;
      end
      if (cmd_i.push) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    raddr_q <= raddr;
    new_q   <= new_d;
    succ_q  <= succ_d;
    if (cmd_i.load_in) begin
      op_q  <= s_data_i[rrts_pkg::OpWidth-1:0];
      tgt_q <= s_data_i[rrts_pkg::OpWidth +: rrts_pkg::SlotWidth];
    end
    if (cmd_i.wr_exit) begin
      j_q <= jn_ent[SW-1:0];
    end
    if (cmd_i.push) begin
      out_q <= {1'b0, succ_q, new_x[2:0], cur_x[2:0]};
    end
  end

  assign m_valid_o = out_valid_q;
  assign m_data_o  = out_q;

  always_comb begin
    sts_o           = '0;
    sts_o.opcode    = op_q;
    sts_o.preempt   = preempt_q;
    sts_o.cur_act   = cur_act_q;
    sts_o.scan_hit  = hit;
    sts_o.scan_miss = miss;
    sts_o.join_pre  = join_pre;
    sts_o.join_ok   = join_ok;
    sts_o.exit_jv   = jn_ent[SW];
    sts_o.out_free  = !out_valid_q || m_ready_i;
  end

endmodule
`default_nettype wire

>>> design/round_robin_thread_scheduler.sv
// top level of the round robin thread scheduler
// depends on rrts_pkg, rrts_ctrl, rrts_dpath (and rrts_ram below it)
`default_nettype none
// Round robin thread scheduler. Keeps SLOT_COUNT thread slots (invalid,
// active, blocked or finished), a joiner per slot and the running slot,
// and answers every input word with exactly one result word. Create takes
// the lowest invalid slot from 1 up; yield and an enabled timer tick scan
// round robin from the slot after the running one; join blocks the
// running slot on an active target; exit finishes the running slot and
// wakes its joiner or scans. One word is handled at a time. Slot tables
// sit in two small rams with one read port each, so the scan looks at one
// slot per cycle and stops at the first slot that it finds. Tick with
// preemption off and undefined opcodes only return a result word. The
// result sits in an output register, so a finished word may wait for
// m_axis_tready while the next input word is taken. The user must see
// that the preemption register is written with cfg_we_i and cfg_wdata_i
// only while the block is idle; the block does not enforce this itself.
module round_robin_thread_scheduler #(
  parameter int unsigned SLOT_COUNT = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  // preempt_enable register
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_wdata_i,
  // input words
  input  wire logic       s_axis_tvalid,
  output logic            s_axis_tready,
  input  wire logic [7:0] s_axis_tdata,  // opcode [2:0], target_thread [5:3], zero [7:6]
  // result words
  output logic            m_axis_tvalid,
  input  wire logic       m_axis_tready,
  output logic      [7:0] m_axis_tdata   // running_slot [2:0], new_slot [5:3], success [6]
);

  rrts_pkg::rrts_cmd_t cmd;
  rrts_pkg::rrts_sts_t sts;

  // sequencing of one word
  rrts_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // slot tables, scan and output register
  rrts_dpath #(.SLOT_COUNT(SLOT_COUNT)) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_data_i    (s_axis_tdata),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
`default_nettype wire

>>> bench/tb_round_robin_thread_scheduler.sv
`timescale 1ns / 1ps
// self-checking bench for round_robin_thread_scheduler: a directed table, then random words
// needs rrts_pkg and the scheduler rtl; keeps its own slot table to predict every result word

module tb_round_robin_thread_scheduler;

  localparam int unsigned SlotCount   = 8;
  localparam int unsigned DrainCycles = SlotCount + 8;  // worst case word latency plus margin
  localparam int unsigned HoldCycles  = 80;             // long receiver stall
  localparam int unsigned RandomWords = 850;
  localparam int unsigned PhaseCount  = 5;

  // undefined opcodes, ignored by the block
  localparam logic [2:0] OP_RSVD_LO = 3'd5;
  localparam logic [2:0] OP_RSVD_HI = 3'd7;

  typedef struct packed {
    logic [2:0] running;
    logic [2:0] new_slot;
    logic       success;
  } sched_word_t;

  typedef struct packed {
    logic [2:0]  op;
    logic [2:0]  tgt;
    logic        cfg_wr;   // drain and write preempt_enable before this word
    logic        cfg_val;
    logic        typed;    // use the literal result below instead of the predictor
    sched_word_t want;
  } sched_row_t;

  logic       clk_i         = 1'b0;
  logic       rst_ni        = 1'b0;
  logic       cfg_we_i      = 1'b0;
  logic       cfg_wdata_i   = 1'b0;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata  = 8'h00;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;

  // predicted scheduler state
  logic [1:0] slot_state [SlotCount];
  logic       has_joiner [SlotCount];
  logic [2:0] joiner_of  [SlotCount];
  logic [2:0] running;
  logic       preempt;

  sched_word_t pending_results[$];

  int unsigned fail_count      = 0;
  int unsigned words_in        = 0;
  int unsigned results_checked = 0;
  int unsigned cfg_writes      = 0;
  int unsigned n_created       = 0;
  int unsigned n_joins         = 0;
  int unsigned n_wakes         = 0;

  logic no_idle      = 1'b0;  // both sides run without gaps while set
  logic hold_out_req = 1'b0;  // asks the receiver for one long stall

  always #5 clk_i = ~clk_i;

  round_robin_thread_scheduler #(
    .SLOT_COUNT(SlotCount)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // round robin search from the slot after the running one, ending on the running slot
  function automatic logic rotate_to_active();
    logic [2:0] cand;
    for (int i = 1; i <= SlotCount; i++) begin
      cand = running + 3'(i);
      if (slot_state[cand] == rrts_pkg::ST_ACTIVE) begin
        running = cand;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // applies one word to the predicted slot table and returns the result word
  function automatic sched_word_t apply_sched_op(input logic [2:0] op, input logic [2:0] tgt);
    sched_word_t r;
    logic [2:0]  cur;
    logic [2:0]  waker;
    r   = '0;
    cur = running;
    case (op)
      rrts_pkg::OP_CREATE: begin
        for (int i = 1; i < SlotCount; i++) begin
          if (!r.success && slot_state[3'(i)] == rrts_pkg::ST_INVALID) begin
            slot_state[3'(i)] = rrts_pkg::ST_ACTIVE;
            has_joiner[3'(i)] = 1'b0;
            joiner_of[3'(i)]  = '0;
            r.new_slot        = 3'(i);
            r.success         = 1'b1;
            n_created++;
          end
        end
      end
      rrts_pkg::OP_YIELD: r.success = rotate_to_active();
      rrts_pkg::OP_JOIN: begin
        // target must be another active slot with no joiner yet
        if (tgt != cur && slot_state[cur] == rrts_pkg::ST_ACTIVE &&
            slot_state[tgt] == rrts_pkg::ST_ACTIVE && !has_joiner[tgt]) begin
          slot_state[cur] = rrts_pkg::ST_BLOCKED;
          has_joiner[tgt] = 1'b1;
          joiner_of[tgt]  = cur;
          running         = tgt;
          r.success       = 1'b1;
          n_joins++;
        end
      end
      rrts_pkg::OP_EXIT: begin
        if (slot_state[cur] == rrts_pkg::ST_ACTIVE) begin
          slot_state[cur] = rrts_pkg::ST_FINISHED;
          if (has_joiner[cur]) begin
            // wake the joiner and hand it the cpu, joiner record is used up
            waker             = joiner_of[cur];
            has_joiner[cur]   = 1'b0;
            slot_state[waker] = rrts_pkg::ST_ACTIVE;
            running           = waker;
            r.success         = 1'b1;
            n_wakes++;
          end else begin
            r.success = rotate_to_active();
          end
        end
      end
      rrts_pkg::OP_TICK: if (preempt) r.success = rotate_to_active();
      default: ;
    endcase
    r.running = running;
    return r;
  endfunction

  function automatic sched_row_t mk_row(input logic [2:0] op, input logic [2:0] tgt,
                                        input logic cfg_wr, input logic cfg_val,
                                        input logic typed, input logic [2:0] run,
                                        input logic [2:0] nslot, input logic succ);
    sched_row_t row;
    row.op      = op;
    row.tgt     = tgt;
    row.cfg_wr  = cfg_wr;
    row.cfg_val = cfg_val;
    row.typed   = typed;
    row.want    = '{running: run, new_slot: nslot, success: succ};
    return row;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (no_idle) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // exits are kept rare: a finished slot never comes back
  function automatic logic [2:0] pick_op();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 16) return rrts_pkg::OP_CREATE;
    if (roll < 40) return rrts_pkg::OP_YIELD;
    if (roll < 64) return rrts_pkg::OP_JOIN;
    if (roll < 67) return rrts_pkg::OP_EXIT;
    if (roll < 94) return rrts_pkg::OP_TICK;
    return 3'($urandom_range(OP_RSVD_HI, OP_RSVD_LO));
  endfunction

  // offers one word and records its expected result once it is taken
  task automatic send_word(input logic [2:0] op, input logic [2:0] tgt, input logic typed,
                           input sched_word_t typed_word);
    int unsigned gap;
    sched_word_t got;
    gap = pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, tgt, op};
    do @(posedge clk_i); while (!s_axis_tready);
    got = apply_sched_op(op, tgt);
    pending_results.push_back(typed ? typed_word : got);
    words_in++;
  endtask

  // sender stays quiet until every expected result word is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_preempt(input logic val);
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    preempt  = val;
    cfg_writes++;
  endtask

  // receiver: random stalls, one long hold on request
  initial begin : result_sink
    int unsigned gap;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_out_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_out_req = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          m_axis_tready <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
    end
  end

  // compares each taken result word with the oldest expectation
  always @(posedge clk_i) begin : result_check
    sched_word_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word 0x%02h with no expectation waiting", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (m_axis_tdata[2:0] !== want.running) begin
          $error("running_slot: expected %0d, got %0d", want.running, m_axis_tdata[2:0]);
          fail_count++;
        end
        if (m_axis_tdata[5:3] !== want.new_slot) begin
          $error("new_slot: expected %0d, got %0d", want.new_slot, m_axis_tdata[5:3]);
          fail_count++;
        end
        if (m_axis_tdata[6] !== want.success) begin
          $error("success: expected %0d, got %0d", want.success, m_axis_tdata[6]);
          fail_count++;
        end
      end
    end
  end

  initial begin : watchdog
    #5ms;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    sched_row_t  rows[$];
    sched_word_t none;
    none = '0;
    for (int i = 0; i < SlotCount; i++) begin
      slot_state[3'(i)] = (i == 0) ? rrts_pkg::ST_ACTIVE : rrts_pkg::ST_INVALID;
      has_joiner[3'(i)] = 1'b0;
      joiner_of[3'(i)]  = '0;
    end
    running = '0;
    preempt = 1'b0;

    // directed walk: every opcode and the odd corners of join, exit and scan
    rows.push_back(mk_row(rrts_pkg::OP_TICK, 3'd0, 1'b0, 1'b0, 1'b1,
                          3'd0, 3'd0, 1'b0));  // tick, preemption off
    rows.push_back(mk_row(OP_RSVD_HI, 3'd7, 1'b0, 1'b0, 1'b1,
                          3'd0, 3'd0, 1'b0));  // undefined opcode
    rows.push_back(mk_row(rrts_pkg::OP_YIELD, 3'd0, 1'b0, 1'b0, 1'b1,
                          3'd0, 3'd0, 1'b1));  // scan lands on itself
    rows.push_back(mk_row(rrts_pkg::OP_JOIN, 3'd0, 1'b0, 1'b0, 1'b1,
                          3'd0, 3'd0, 1'b0));  // join on running slot
    rows.push_back(mk_row(rrts_pkg::OP_JOIN, 3'd7, 1'b0, 1'b0, 1'b1,
                          3'd0, 3'd0, 1'b0));  // join on invalid slot
    rows.push_back(mk_row(rrts_pkg::OP_CREATE, 3'd6, 1'b0, 1'b0, 1'b1,
                          3'd0, 3'd1, 1'b1));  // first create
    rows.push_back(mk_row(rrts_pkg::OP_JOIN, 3'd1, 1'b0, 1'b0, 1'b0,
                          3'd0, 3'd0, 1'b0));  // 0 waits on 1
    rows.push_back(mk_row(rrts_pkg::OP_JOIN, 3'd0, 1'b0, 1'b0, 1'b0,
                          3'd0, 3'd0, 1'b0));  // blocked target
    rows.push_back(mk_row(rrts_pkg::OP_EXIT, 3'd5, 1'b0, 1'b0, 1'b0,
                          3'd0, 3'd0, 1'b0));  // exit wakes joiner
    rows.push_back(mk_row(rrts_pkg::OP_JOIN, 3'd1, 1'b0, 1'b0, 1'b0,
                          3'd0, 3'd0, 1'b0));  // finished target
    rows.push_back(mk_row(rrts_pkg::OP_EXIT, 3'd0, 1'b0, 1'b0, 1'b0,
                          3'd0, 3'd0, 1'b0));  // nothing left active
    rows.push_back(mk_row(rrts_pkg::OP_EXIT, 3'd0, 1'b0, 1'b0, 1'b0,
                          3'd0, 3'd0, 1'b0));  // running slot finished
    rows.push_back(mk_row(rrts_pkg::OP_CREATE, 3'd0, 1'b0, 1'b0, 1'b0,
                          3'd0, 3'd0, 1'b0));
    rows.push_back(mk_row(rrts_pkg::OP_JOIN, 3'd2, 1'b0, 1'b0, 1'b0,
                          3'd0, 3'd0, 1'b0));  // join from dead slot
    rows.push_back(mk_row(rrts_pkg::OP_YIELD, 3'd3, 1'b0, 1'b0, 1'b0,
                          3'd0, 3'd0, 1'b0));
    for (int i = 0; i < 5; i++) begin
      rows.push_back(mk_row(rrts_pkg::OP_CREATE, 3'd7, 1'b0, 1'b0, 1'b0,
                            3'd0, 3'd0, 1'b0));
    end
    rows.push_back(mk_row(rrts_pkg::OP_CREATE, 3'd0, 1'b0, 1'b0, 1'b0,
                          3'd0, 3'd0, 1'b0));  // table full
    rows.push_back(mk_row(rrts_pkg::OP_JOIN, 3'd5, 1'b0, 1'b0, 1'b0,
                          3'd0, 3'd0, 1'b0));
    rows.push_back(mk_row(rrts_pkg::OP_TICK, 3'd0, 1'b1, 1'b1, 1'b0,
                          3'd0, 3'd0, 1'b0));  // preemption on
    rows.push_back(mk_row(rrts_pkg::OP_TICK, 3'd4, 1'b0, 1'b0, 1'b0,
                          3'd0, 3'd0, 1'b0));
    rows.push_back(mk_row(rrts_pkg::OP_TICK, 3'd0, 1'b0, 1'b0, 1'b0,
                          3'd0, 3'd0, 1'b0));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[k]) begin
      if (rows[k].cfg_wr) write_preempt(rows[k].cfg_val);
      send_word(rows[k].op, rows[k].tgt, rows[k].typed, rows[k].want);
    end

    // random phases with preemption toggled between them
    for (int p = 0; p < PhaseCount; p++) begin
      write_preempt(p[0]);
      for (int n = 0; n < RandomWords / PhaseCount; n++) begin
        if (n % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
        if (p == 1 && n == 30) begin
          // receiver holds off while words keep coming, so the input stalls
          no_idle      = 1'b1;
          hold_out_req = 1'b1;
        end
        send_word(pick_op(), 3'($urandom_range(0, SlotCount - 1)), 1'b0, none);
      end
    end

    drain_results();
    repeat (DrainCycles) @(posedge clk_i);

    $display("run covered %0d words, %0d result words checked, %0d preemption writes",
             words_in, results_checked, cfg_writes);
    $display("slots created %0d, joins taken %0d, joiners woken %0d",
             n_created, n_joins, n_wakes);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/rrts_pkg.sv
design/rrts_ram.sv
design/rrts_ctrl.sv
design/rrts_dpath.sv
design/round_robin_thread_scheduler.sv
bench/tb_round_robin_thread_scheduler.sv
